### src/aps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_pkg
// Shared types and constants of the archive path sanitizer.
// ----------------------------------------------------------------------------
package aps_pkg;

    // special bytes of an entry name
    localparam logic [7:0] C_NUL     = 8'h00;
    localparam logic [7:0] C_SLASH   = 8'h2F;
    localparam logic [7:0] C_BSLASH  = 8'h5C;
    localparam logic [7:0] C_COLON   = 8'h3A;
    localparam logic [7:0] C_DOT     = 8'h2E;
    localparam logic [7:0] C_UPPER_A = 8'h41;
    localparam logic [7:0] C_UPPER_Z = 8'h5A;
    localparam logic [7:0] C_LOWER_A = 8'h61;
    localparam logic [7:0] C_LOWER_Z = 8'h7A;

    // buffer capacity limits
    localparam logic [10:0] C_OUT_SIZE_RST = 11'd1024;
    localparam logic [10:0] C_MAX_OUT      = 11'd1024;

    // slack needed before the first separator (separator and terminator room)
    localparam logic [11:0] C_SLACK_FIRST = 12'd2;
    localparam logic [11:0] C_SLACK_LATER = 12'd1;

    // held component byte count that marks a streaming component
    localparam logic [1:0] C_CNT_STREAM = 2'd3;

    // position within a name
    typedef enum logic [2:0] {
        POS_FIRST  = 3'b001,
        POS_LETTER = 3'b010,
        POS_BODY   = 3'b100
    } t_pos;

    // all results caused by one item: bytes first, then an optional done
    typedef struct packed {
        logic [3:0][7:0] ch;
        logic [2:0]      nbytes;
        logic            done;
        logic            ok;
        logic [10:0]     len;
    } t_res_buf;

endpackage
`default_nettype wire

### src/aps_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_core
// Name state and the single-pass step logic for one name byte.
// ----------------------------------------------------------------------------
module aps_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [7:0]       i_ch,
    input  wire logic [10:0]      i_cap,
    output aps_pkg::t_res_buf     o_rb
);
    import aps_pkg::*;

    typedef struct packed {
        t_pos        pos;
        logic [7:0]  fb;
        logic [7:0]  h0;
        logic [7:0]  h1;
        logic [1:0]  cnt;
        logic [10:0] len;
        logic        rej;
        logic        sep;
    } t_name_st;

    typedef struct packed {
        t_name_st st;
        t_res_buf rb;
    } t_work;

    localparam t_name_st C_ST_CLEAR = '{
        pos: POS_FIRST, fb: 8'd0, h0: 8'd0, h1: 8'd0,
        cnt: 2'd0, len: 11'd0, rej: 1'b0, sep: 1'b0
    };

    t_name_st r_st;
    t_name_st n_st;
    t_res_buf n_rb;

    // emit one byte if the capacity allows, else reject the name
    function automatic t_work f_emit(t_work w, logic [7:0] c, logic [10:0] cap);
        t_work       r;
        logic [11:0] nxt;
        logic [11:0] slack;
        r     = w;
        nxt   = {1'b0, w.st.len} + 12'd1;
        slack = w.st.sep ? C_SLACK_LATER : C_SLACK_FIRST;
        if (!w.st.rej) begin
            if (nxt + slack > {1'b0, cap}) begin
                r.st.rej = 1'b1;
            end else begin
                r.rb.ch[w.rb.nbytes[1:0]] = c;
                r.rb.nbytes               = w.rb.nbytes + 3'd1;
                r.st.len                  = nxt[10:0];
            end
        end
        return r;
    endfunction

    // separator ahead of every component but the first
    function automatic t_work f_begin(t_work w, logic [10:0] cap);
        t_work r;
        r = w;
        if (w.st.len != 11'd0) begin
            r.st.sep = 1'b1;
            r = f_emit(r, C_SLASH, cap);
        end
        return r;
    endfunction

    // flush a short held component at a separator or the end
    function automatic t_work f_finish(t_work w, logic [10:0] cap);
        t_work r;
        r = w;
        if (w.st.cnt == 2'd1) begin
            if (w.st.h0 != C_DOT) begin
                r = f_begin(r, cap);
                r = f_emit(r, w.st.h0, cap);
            end
        end else if (w.st.cnt == 2'd2) begin
            if (w.st.h0 == C_DOT && w.st.h1 == C_DOT) begin
                r.st.rej = 1'b1;
            end else begin
                r = f_begin(r, cap);
                r = f_emit(r, w.st.h0, cap);
                r = f_emit(r, w.st.h1, cap);
            end
        end
        r.st.cnt = 2'd0;
        return r;
    endfunction

    // one byte of the name body
    function automatic t_work f_body(t_work w, logic [7:0] c, logic [10:0] cap);
        t_work r;
        r = w;
        if (c == C_SLASH || c == C_BSLASH) begin
            r = f_finish(r, cap);
        end else if (w.st.cnt == 2'd0) begin
            r.st.h0  = c;
            r.st.cnt = 2'd1;
        end else if (w.st.cnt == 2'd1) begin
            r.st.h1  = c;
            r.st.cnt = 2'd2;
        end else if (w.st.cnt == 2'd2) begin
            r = f_begin(r, cap);
            r = f_emit(r, w.st.h0, cap);
            r = f_emit(r, w.st.h1, cap);
            r = f_emit(r, c, cap);
            r.st.cnt = C_CNT_STREAM;
        end else begin
            r = f_emit(r, c, cap);
        end
        return r;
    endfunction

    // step logic for the held input byte
    always_comb begin
        t_work w;
        logic  go_on;
        logic  letter;
        w.st   = r_st;
        w.rb   = '0;
        go_on  = 1'b1;
        letter = (i_ch >= C_UPPER_A && i_ch <= C_UPPER_Z) ||
                 (i_ch >= C_LOWER_A && i_ch <= C_LOWER_Z);
        unique case (r_st.pos)
            POS_FIRST: begin
                if (letter) begin
                    w.st.fb  = i_ch;
                    w.st.pos = POS_LETTER;
                    go_on    = 1'b0;
                end else begin
                    w.st.pos = POS_BODY;
                end
            end
            POS_LETTER: begin
                w.st.pos = POS_BODY;
                if (i_ch == C_COLON) begin
                    go_on = 1'b0;
                end else begin
                    w = f_body(w, r_st.fb, i_cap);
                end
            end
            POS_BODY: begin
                go_on = 1'b1;
            end
            default: begin
                w.st.pos = POS_BODY;
            end
        endcase
        if (go_on) begin
            if (i_ch != C_NUL) begin
                w = f_body(w, i_ch, i_cap);
            end else begin
                w         = f_finish(w, i_cap);
                w.rb.done = 1'b1;
                w.rb.ok   = !w.st.rej && (w.st.len != 11'd0);
                w.rb.len  = w.st.len;
                w.st      = C_ST_CLEAR;
            end
        end
        n_st = w.st;
        n_rb = w.rb;
    end

    // name state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= C_ST_CLEAR;
        end else if (i_go) begin
            r_st <= n_st;
        end
    end

    assign o_rb = n_rb;

endmodule
`default_nettype wire

### src/aps_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aps_out_buf
// Result register: holds the results of one item and hands them out one
// per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module aps_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  aps_pkg::t_res_buf     i_rb,
    output logic                  o_free,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [7:0]            o_out_ch,
    output logic                  o_done_res,
    output logic                  o_ok,
    output logic [10:0]           o_out_len
);
    import aps_pkg::*;

    t_res_buf   r_rb;
    logic [2:0] r_rd;
    logic [2:0] r_left;
    logic [2:0] n_rd;
    logic [2:0] n_left;
    logic       pop;
    logic       is_byte;

    assign pop    = (r_left != 3'd0) && !i_out_stall;
    assign o_free = (r_left == 3'd0) || (r_left == 3'd1 && pop);

    // read pointer and remaining count
    always_comb begin
        n_rd   = r_rd;
        n_left = r_left;
        if (i_load) begin
            n_rd   = 3'd0;
            n_left = i_rb.nbytes + {2'b00, i_rb.done};
        end else if (pop) begin
            n_rd   = r_rd + 3'd1;
            n_left = r_left - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd   <= 3'd0;
            r_left <= 3'd0;
        end else begin
            r_rd   <= n_rd;
            r_left <= n_left;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rb <= i_rb;
        end
    end

    // bytes come first, the done item last
    assign is_byte     = r_rd < r_rb.nbytes;
    assign o_out_valid = r_left != 3'd0;
    assign o_out_ch    = is_byte ? r_rb.ch[r_rd[1:0]] : C_NUL;
    assign o_done_res  = !is_byte;
    assign o_ok        = is_byte ? 1'b0 : r_rb.ok;
    assign o_out_len   = is_byte ? 11'd0 : r_rb.len;

`ifndef ASSERT_OFF
    a_load_when_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("result buffer loaded while still busy");

    a_count_track : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 3'd0) |-> (r_rd + r_left == r_rb.nbytes + {2'b00, r_rb.done}))
        else $error("read pointer and remaining count disagree");

    a_done_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (r_left == 3'd1 && r_rb.done))
        else $error("done item is not the last of its item");
`endif

endmodule
`default_nettype wire

### src/archive_path_sanitizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// archive_path_sanitizer_unit
// Streaming sanitizer for archive entry names, one name byte per item.
// ----------------------------------------------------------------------------
// flow: an accepted item waits in the input register, moves into the result
//   register once that is free, and its results are offered from there
// throughput: one item per cycle while each item gives at most one result and no
//   output stall; an item giving more holds the result register till all are taken
// reset: synchronous, active low; clears name state, empties both registers,
//   out_size returns to 1024
// ----------------------------------------------------------------------------
module archive_path_sanitizer_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [10:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_ch,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_ch,
    output logic             o_done_res,
    output logic             o_ok,
    output logic [10:0]      o_out_len
);
    import aps_pkg::*;

    logic [10:0] r_out_size;
    logic        r_in_valid;
    logic [7:0]  r_in_ch;
    logic [10:0] cap;
    logic        buf_free;
    logic        go;
    logic        in_take;
    t_res_buf    rb;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_size <= C_OUT_SIZE_RST;
        end else if (i_cfg_we) begin
            r_out_size <= i_cfg_data;
        end
    end

    assign cap = (r_out_size > C_MAX_OUT) ? C_MAX_OUT : r_out_size;

    // input register
    assign go         = r_in_valid && buf_free;
    assign o_in_stall = r_in_valid && !buf_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ch <= i_ch;
        end
    end

    // step logic and name state
    aps_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_ch    (r_in_ch),
        .i_cap   (cap),
        .o_rb    (rb)
    );

    // result register
    aps_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go),
        .i_rb        (rb),
        .o_free      (buf_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_ch    (o_out_ch),
        .o_done_res  (o_done_res),
        .o_ok        (o_ok),
        .o_out_len   (o_out_len)
    );

`ifndef ASSERT_OFF
    a_stall_needs_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with no item held");

    a_held_item_kept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !go) |=> (r_in_valid && $stable(r_in_ch)))
        else $error("held input item lost or changed");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("block not empty after reset");
`endif

endmodule
`default_nettype wire
